/* hdl/rotatable_bond_classifier_defines.svh */
// Assertion macros for the rotatable bond classifier
`ifndef ROTATABLE_BOND_CLASSIFIER_DEFINES_SVH
`define ROTATABLE_BOND_CLASSIFIER_DEFINES_SVH

// check cons in the same cycle as ante
`define RBC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define RBC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rbc_pkg.sv */
// Shared types and codes for the rotatable bond classifier
`timescale 1ns / 1ps
package rbc_pkg;

	typedef enum logic [1:0] {
		CMD_ATOM  = 2'd0,
		CMD_BOND  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} rbc_cmd_t;

	localparam logic [2:0] EL_C = 3'd1;
	localparam logic [2:0] EL_N = 3'd2;
	localparam logic [2:0] EL_O = 3'd3;
	localparam logic [2:0] EL_S = 3'd4;

	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_DOUBLE = 2'd1;
	localparam logic [1:0] KIND_TRIPLE = 2'd2;

	localparam int unsigned MIN_DEGREE = 2;

	typedef enum logic [2:0] {
		RSN_OK         = 3'd0,
		RSN_NOT_SINGLE = 3'd1,
		RSN_RING       = 3'd2,
		RSN_TERMINAL   = 3'd3,
		RSN_AMIDE      = 3'd4,
		RSN_DISULFIDE  = 3'd5,
		RSN_TRIPLE_ADJ = 3'd6,
		RSN_CONJ_CN    = 3'd7
	} rbc_reason_t;

	typedef struct packed {
		logic [2:0] element;
		logic       aromatic;
		logic       amide_n;
		logic       has_triple;
		logic       dbl_o;
		logic       dbl_n;
		logic       dbl_any;
		logic       low_degree;
	} rbc_atom_view_t;

endpackage

/* hdl/rbc_rules.sv */
// Rule chain that picks the first failing reason for one bond
`timescale 1ns / 1ps
module rbc_rules
	import rbc_pkg::*;
(
	input  logic [1:0]     bond_kind,
	input  logic           ring_member,
	input  rbc_atom_view_t x,
	input  rbc_atom_view_t y,
	output rbc_reason_t    reason
);

	logic           cn_pair;
	rbc_atom_view_t c_atom;
	rbc_atom_view_t n_atom;

	always_comb begin
		cn_pair = 1'b1;
		c_atom  = x;
		n_atom  = y;
		if (x.element == EL_C && y.element == EL_N) begin
			c_atom = x;
			n_atom = y;
		end else if (y.element == EL_C && x.element == EL_N) begin
			c_atom = y;
			n_atom = x;
		end else begin
			cn_pair = 1'b0;
		end
	end

	always_comb begin
		if (bond_kind != KIND_SINGLE) begin
			reason = RSN_NOT_SINGLE;
		end else if (ring_member) begin
			reason = RSN_RING;
		end else if (x.low_degree || y.low_degree) begin
			reason = RSN_TERMINAL;
		end else if (cn_pair && c_atom.dbl_o) begin
			reason = RSN_AMIDE;
		end else if (x.element == EL_S && y.element == EL_S) begin
			reason = RSN_DISULFIDE;
		end else if (x.has_triple || y.has_triple) begin
			reason = RSN_TRIPLE_ADJ;
		end else if (cn_pair && (n_atom.amide_n || c_atom.dbl_n || c_atom.dbl_any
				|| c_atom.aromatic)) begin
			reason = RSN_CONJ_CN;
		end else begin
			reason = RSN_OK;
		end
	end

endmodule

/* hdl/rotatable_bond_classifier.sv */
// Top level: atom and bond tables, update sequencer and query path
//
// channel | dir | tdata                                   | tuser
// s       | in  | slot,element,aromatic,amide,a,b,kind,ring | cmd
// m       | out | queried_bond,rotatable,reason            | -
//
// Atom load: written straight from idle. Bond load: two atom reads then two atom
// writes through the single atom table port. Query: one bond read then two
// atom reads, plus any wait for the result register to drain.
// s_tready is high only while the sequencer is idle. Tables need no clearing
// after reset; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`include "rotatable_bond_classifier_defines.svh"
module rotatable_bond_classifier
	import rbc_pkg::*;
#(
	parameter int MAX_ATOMS   = 256,
	parameter int MAX_BONDS   = 256,
	parameter int DEGREE_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] slot, [10:8] element_code, [11] aromatic_atom, [12] amide_nitrogen,
	// [20:13] end_a, [28:21] end_b, [30:29] bond_kind, [31] ring_member
	input  logic [31:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] queried_bond, [8] rotatable, [11:9] reason, [15:12] zero
	output logic [15:0] m_tdata
);

	localparam int AW = $clog2(MAX_ATOMS);
	localparam int BW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
	localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};

	typedef struct packed {
		logic [2:0]             element;
		logic                   aromatic;
		logic                   amide_n;
		logic [DEGREE_BITS-1:0] degree;
		logic                   has_triple;
		logic                   dbl_o;
		logic                   dbl_n;
		logic                   dbl_any;
	} atom_t;

	typedef struct packed {
		logic [AW-1:0] a;
		logic [AW-1:0] b;
		logic [1:0]    kind;
		logic          ring;
	} bond_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_BRD_A = 8'b0000_0010,
		ST_BRD_B = 8'b0000_0100,
		ST_BWR_A = 8'b0000_1000,
		ST_BWR_B = 8'b0001_0000,
		ST_QRD_A = 8'b0010_0000,
		ST_QRD_B = 8'b0100_0000,
		ST_QEVAL = 8'b1000_0000
	} state_t;

	atom_t atom_mem [MAX_ATOMS];
	bond_t bond_mem [MAX_BONDS];

	state_t state_q;
	atom_t  atom_rd_q;
	atom_t  atom_x_q;
	bond_t  bond_rd_q;
	bond_t  bnd_q;
	logic [7:0] qslot_q;

	logic        m_valid_q;
	logic [7:0]  out_slot_q;
	logic        out_rot_q;
	rbc_reason_t out_reason_q;

	logic [7:0] in_slot;
	logic [2:0] in_element;
	logic       in_aromatic;
	logic       in_amide;
	logic [7:0] in_end_a;
	logic [7:0] in_end_b;
	logic [1:0] in_kind;
	logic       in_ring;
	rbc_cmd_t   in_cmd;

	logic accept;
	logic atom_ok;
	logic bond_ok;
	logic query_ok;

	logic          atom_we;
	logic [AW-1:0] atom_wa;
	atom_t         atom_wd;
	logic          atom_re;
	logic [AW-1:0] atom_ra;
	bond_t         bond_wd;

	atom_t      touch_base;
	atom_t      touch_res;
	logic [2:0] touch_oel;

	rbc_atom_view_t view_x;
	rbc_atom_view_t view_y;
	rbc_reason_t    rule_reason;
	logic           eval_done;

	assign in_slot     = s_tdata[7:0];
	assign in_element  = s_tdata[10:8];
	assign in_aromatic = s_tdata[11];
	assign in_amide    = s_tdata[12];
	assign in_end_a    = s_tdata[20:13];
	assign in_end_b    = s_tdata[28:21];
	assign in_kind     = s_tdata[30:29];
	assign in_ring     = s_tdata[31];
	assign in_cmd      = rbc_cmd_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign atom_ok  = accept && in_cmd == CMD_ATOM && 32'(in_slot) < MAX_ATOMS;
	assign bond_ok  = accept && in_cmd == CMD_BOND && 32'(in_slot) < MAX_BONDS
		&& 32'(in_end_a) < MAX_ATOMS && 32'(in_end_b) < MAX_ATOMS;
	assign query_ok = accept && in_cmd == CMD_QUERY && 32'(in_slot) < MAX_BONDS;

	assign bond_wd.a    = AW'(in_end_a);
	assign bond_wd.b    = AW'(in_end_b);
	assign bond_wd.kind = in_kind;
	assign bond_wd.ring = in_ring;

	// shared atom update unit
	always_comb begin
		touch_base = (state_q == ST_BWR_A) ? atom_x_q : atom_rd_q;
		touch_oel  = (state_q == ST_BWR_A) ? atom_rd_q.element : atom_x_q.element;
		if (state_q == ST_BWR_B && bnd_q.a == bnd_q.b) begin
			touch_base = atom_x_q;
		end
		touch_res = touch_base;
		if (touch_base.degree != DEG_MAX) begin
			touch_res.degree = touch_base.degree + 1'b1;
		end
		if (bnd_q.kind == KIND_TRIPLE) begin
			touch_res.has_triple = 1'b1;
		end
		if (bnd_q.kind == KIND_DOUBLE) begin
			touch_res.dbl_any = 1'b1;
			if (touch_oel == EL_O) begin
				touch_res.dbl_o = 1'b1;
			end
			if (touch_oel == EL_N) begin
				touch_res.dbl_n = 1'b1;
			end
		end
	end

	always_comb begin
		atom_we = 1'b0;
		atom_wa = AW'(in_slot);
		atom_wd = '0;
		atom_wd.element  = in_element;
		atom_wd.aromatic = in_aromatic;
		atom_wd.amide_n  = in_amide;
		atom_re = 1'b0;
		atom_ra = bnd_q.a;
		case (state_q)
			ST_IDLE: begin
				atom_we = atom_ok;
			end
			ST_BRD_A: begin
				atom_re = 1'b1;
				atom_ra = bnd_q.a;
			end
			ST_BRD_B: begin
				atom_re = 1'b1;
				atom_ra = bnd_q.b;
			end
			ST_BWR_A: begin
				atom_we = 1'b1;
				atom_wa = bnd_q.a;
				atom_wd = touch_res;
			end
			ST_BWR_B: begin
				atom_we = 1'b1;
				atom_wa = bnd_q.b;
				atom_wd = touch_res;
			end
			ST_QRD_A: begin
				atom_re = 1'b1;
				atom_ra = bond_rd_q.a;
			end
			ST_QRD_B: begin
				atom_re = 1'b1;
				atom_ra = bond_rd_q.b;
			end
			default: begin
				atom_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (atom_we) begin
			atom_mem[atom_wa] <= atom_wd;
		end
		if (atom_re) begin
			atom_rd_q <= atom_mem[atom_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (bond_ok) begin
			bond_mem[BW'(in_slot)] <= bond_wd;
		end
		if (query_ok) begin
			bond_rd_q <= bond_mem[BW'(in_slot)];
		end
	end

	always_ff @(posedge clk) begin
		if (bond_ok) begin
			bnd_q <= bond_wd;
		end
		if (query_ok) begin
			qslot_q <= in_slot;
		end
		case (state_q)
			ST_BRD_B, ST_QRD_B: begin
				atom_x_q <= atom_rd_q;
			end
			ST_BWR_A: begin
				atom_x_q <= touch_res;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		view_x.element    = atom_x_q.element;
		view_x.aromatic   = atom_x_q.aromatic;
		view_x.amide_n    = atom_x_q.amide_n;
		view_x.has_triple = atom_x_q.has_triple;
		view_x.dbl_o      = atom_x_q.dbl_o;
		view_x.dbl_n      = atom_x_q.dbl_n;
		view_x.dbl_any    = atom_x_q.dbl_any;
		view_x.low_degree = 32'(atom_x_q.degree) < MIN_DEGREE;
		view_y.element    = atom_rd_q.element;
		view_y.aromatic   = atom_rd_q.aromatic;
		view_y.amide_n    = atom_rd_q.amide_n;
		view_y.has_triple = atom_rd_q.has_triple;
		view_y.dbl_o      = atom_rd_q.dbl_o;
		view_y.dbl_n      = atom_rd_q.dbl_n;
		view_y.dbl_any    = atom_rd_q.dbl_any;
		view_y.low_degree = 32'(atom_rd_q.degree) < MIN_DEGREE;
	end

	rbc_rules u_rules (
		.bond_kind   (bond_rd_q.kind),
		.ring_member (bond_rd_q.ring),
		.x           (view_x),
		.y           (view_y),
		.reason      (rule_reason)
	);

	assign eval_done = (state_q == ST_QEVAL) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (bond_ok) begin
						state_q <= ST_BRD_A;
					end else if (query_ok) begin
						state_q <= ST_QRD_A;
					end
				end
				ST_BRD_A: state_q <= ST_BRD_B;
				ST_BRD_B: state_q <= ST_BWR_A;
				ST_BWR_A: state_q <= ST_BWR_B;
				ST_BWR_B: state_q <= ST_IDLE;
				ST_QRD_A: state_q <= ST_QRD_B;
				ST_QRD_B: state_q <= ST_QEVAL;
				ST_QEVAL: begin
					if (eval_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (eval_done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_done) begin
			out_slot_q   <= qslot_q;
			out_rot_q    <= (rule_reason == RSN_OK);
			out_reason_q <= rule_reason;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_reason_q, out_rot_q, out_slot_q};

	`RBC_ASSERT_NEXT(a_bond_seq, clk, arst_n, bond_ok, state_q == ST_BRD_A,
		"bond load did not start atom update")
	`RBC_ASSERT_NOW(a_out_src, clk, arst_n, $rose(m_valid_q), $past(state_q == ST_QEVAL),
		"result appeared without evaluation")
	`RBC_ASSERT_NOW(a_rot_reason, clk, arst_n, m_valid_q,
		out_rot_q == (out_reason_q == RSN_OK), "rotatable flag disagrees with reason")

endmodule
